// File: rtl/sab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types, constants and helpers of the sprite alpha blender.
// ----------------------------------------------------------------------------
package sab_pkg;

  // sprite edge in pixels; offsets at or above it are not sprite pixels
  localparam int unsigned SPRITE_SIZE = 64;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned SUM_W   = COORD_W + 1;
  localparam int unsigned OFS_W   = 6;
  localparam int unsigned ADDR_W  = 22;
  localparam int unsigned MIX_W   = 14;  // a*s + (255-a)*d + 127 stays below 2^14
  localparam int unsigned PROD_W  = 2 * COORD_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [COORD_W-1:0] WIDTH_RESET  = 12'd1024;
  localparam logic [COORD_W-1:0] HEIGHT_RESET = 12'd768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1
  } cfg_reg_t;

  // stage 1 -> stage 2
  typedef struct packed {
    logic signed [SUM_W-1:0] col;
    logic signed [SUM_W-1:0] row;
    logic                    in_sprite;
    logic [MIX_W-1:0]        mix_r;
    logic [MIX_W-1:0]        mix_g;
    logic [MIX_W-1:0]        mix_b;
  } s1_t;

  // stage 2 -> output stage
  typedef struct packed {
    logic               on;
    logic [COORD_W-1:0] col;
    logic [PROD_W-1:0]  row_base;
    logic [4:0]         r;
    logic [5:0]         g;
    logic [4:0]         b;
  } s2_t;

  // exact x / 255 for the weighted sums; x + x/256 + 1 stays below 2^14
  function automatic logic [5:0] div255(input logic [MIX_W-1:0] x);
    logic [MIX_W-1:0] t;
    begin
      t = x + {{(MIX_W-6){1'b0}}, x[MIX_W-1:8]} + {{(MIX_W-1){1'b0}}, 1'b1};
      div255 = t[MIX_W-1:8];
    end
  endfunction

endpackage

// File: rtl/sab_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_pix_if
// Pixel item channel: sprite color, destination pixel and position.
// ----------------------------------------------------------------------------
interface sab_pix_if;
  logic        valid;
  logic        ready;
  logic [7:0]  sprite_blue;
  logic [7:0]  sprite_green;
  logic [7:0]  sprite_red;
  logic [7:0]  sprite_alpha;
  logic [15:0] dest_color;
  logic signed [11:0] origin_x;
  logic signed [11:0] origin_y;
  logic [5:0]  offset_x;
  logic [5:0]  offset_y;

  modport source (
    output valid, sprite_blue, sprite_green, sprite_red, sprite_alpha,
    output dest_color, origin_x, origin_y, offset_x, offset_y,
    input  ready
  );
  modport sink (
    input  valid, sprite_blue, sprite_green, sprite_red, sprite_alpha,
    input  dest_color, origin_x, origin_y, offset_x, offset_y,
    output ready
  );
endinterface

// File: rtl/sab_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_res_if
// Result item channel: write enable, framebuffer address and color.
// ----------------------------------------------------------------------------
interface sab_res_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [21:0] pixel_address;
  logic [15:0] blended_color;

  modport source (
    output valid, write_enable, pixel_address, blended_color,
    input  ready
  );
  modport sink (
    input  valid, write_enable, pixel_address, blended_color,
    output ready
  );
endinterface

// File: rtl/sab_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sab_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/sab_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_front
// Stage 1: screen position sums, sprite bounds and per-channel weighted sums.
// ----------------------------------------------------------------------------
module sab_front
  import sab_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic [7:0]        sprite_blue,
  input  logic [7:0]        sprite_green,
  input  logic [7:0]        sprite_red,
  input  logic [7:0]        sprite_alpha,
  input  logic [15:0]       dest_color,
  input  logic [COORD_W-1:0] origin_x,
  input  logic [COORD_W-1:0] origin_y,
  input  logic [OFS_W-1:0]  offset_x,
  input  logic [OFS_W-1:0]  offset_y,
  output s1_t               s1
);

  s1_t        s1_next;
  logic [7:0] inv_a;

  // a*s + (255-a)*d + 127, all terms zero-extended to the sum width
  function automatic logic [MIX_W-1:0] wsum(input logic [7:0] a, input logic [7:0] na,
                                            input logic [5:0] s, input logic [5:0] d);
    begin
      wsum = ({{(MIX_W-8){1'b0}}, a} * {{(MIX_W-6){1'b0}}, s})
           + ({{(MIX_W-8){1'b0}}, na} * {{(MIX_W-6){1'b0}}, d})
           + MIX_W'(127);
    end
  endfunction

  always_comb begin
    inv_a           = 8'd255 - sprite_alpha;
    s1_next.col     = {origin_x[COORD_W-1], origin_x} + {{(SUM_W-OFS_W){1'b0}}, offset_x};
    s1_next.row     = {origin_y[COORD_W-1], origin_y} + {{(SUM_W-OFS_W){1'b0}}, offset_y};
    s1_next.in_sprite = ({3'b0, offset_x} < 9'(SPRITE_SIZE))
                     && ({3'b0, offset_y} < 9'(SPRITE_SIZE));
    s1_next.mix_r   = wsum(sprite_alpha, inv_a, {1'b0, sprite_red[7:3]},
                           {1'b0, dest_color[15:11]});
    s1_next.mix_g   = wsum(sprite_alpha, inv_a, sprite_green[7:2], dest_color[10:5]);
    s1_next.mix_b   = wsum(sprite_alpha, inv_a, {1'b0, sprite_blue[7:3]},
                           {1'b0, dest_color[4:0]});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1 <= s1_next;
    end
  end

endmodule

// File: rtl/sab_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_clip
// Stage 2: screen clipping, row base multiply and divide by 255.
// ----------------------------------------------------------------------------
module sab_clip
  import sab_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic [COORD_W-1:0] screen_width,
  input  logic [COORD_W-1:0] screen_height,
  input  s1_t                s1,
  output s2_t                s2
);

  s2_t        s2_next;
  logic [5:0] q_r;
  logic [5:0] q_b;

  always_comb begin
    q_r = div255(s1.mix_r);
    q_b = div255(s1.mix_b);
    s2_next.on = s1.in_sprite
              && !s1.col[SUM_W-1] && (s1.col[COORD_W-1:0] < screen_width)
              && !s1.row[SUM_W-1] && (s1.row[COORD_W-1:0] < screen_height);
    s2_next.col      = s1.col[COORD_W-1:0];
    s2_next.row_base = {{COORD_W{1'b0}}, s1.row[COORD_W-1:0]}
                     * {{COORD_W{1'b0}}, screen_width};
    s2_next.r = q_r[4:0];
    s2_next.g = div255(s1.mix_g);
    s2_next.b = q_b[4:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2 <= s2_next;
    end
  end

endmodule

// File: rtl/sprite_alpha_blend_rgb565.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_alpha_blend_rgb565
// Blends a BGRA8888 sprite pixel over an RGB565 framebuffer pixel.
// ----------------------------------------------------------------------------
// usage:
//   pix  - one item per sprite pixel: sprite color and alpha, the current
//          framebuffer pixel, the sprite origin and the offset inside it
//   res  - one item per pixel item: write_enable, pixel_address and the
//          blended color; clipped pixels come out with all three at zero
//   cfg  - register writes: index 0 screen width, index 1 screen height;
//          always ready, write only while no item is in flight
// timing:
//   three register stages (weighted sums, clip and divide by 255, output
//   register); an item taken moves through the weighted-sum and clip
//   registers into the output register, where it is offered as a result
//   one item per cycle sustained while res.ready is high; each stage refills
//   as soon as the one after it moves, so bubbles are squeezed out on a stall
// reset:
//   rst empties the pipe and loads width 1024 and height 768
// stall:
//   res.ready low holds the output register; earlier stages keep taking
//   items until they fill, then pix.ready drops
// ----------------------------------------------------------------------------
module sprite_alpha_blend_rgb565
  import sab_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sab_pix_if.sink   pix,
  sab_res_if.source res,
  sab_cfg_if.sink   cfg
);

  // screen geometry registers
  logic [COORD_W-1:0] screen_width;
  logic [COORD_W-1:0] screen_height;

  // stage valid bits and per-stage load enables
  logic v1, v2, v3;
  logic en1, en2, en3;

  s1_t s1;
  s2_t s2;

  // output register payload
  logic              write_enable;
  logic [ADDR_W-1:0] pixel_address;
  logic [15:0]       blended_color;
  logic [ADDR_W-1:0] addr_next;

  // a stage loads when it is empty or its contents move on this cycle
  assign en3 = !v3 || res.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign pix.ready = en1;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_SCREEN_WIDTH:  screen_width  <= cfg.data;
        REG_SCREEN_HEIGHT: screen_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= pix.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // stage 1: sums and weighted channel mixes
  sab_front u_front (
    .clk          (clk),
    .load         (en1),
    .sprite_blue  (pix.sprite_blue),
    .sprite_green (pix.sprite_green),
    .sprite_red   (pix.sprite_red),
    .sprite_alpha (pix.sprite_alpha),
    .dest_color   (pix.dest_color),
    .origin_x     (pix.origin_x),
    .origin_y     (pix.origin_y),
    .offset_x     (pix.offset_x),
    .offset_y     (pix.offset_y),
    .s1           (s1)
  );

  // stage 2: clipping, row base and the divides
  sab_clip u_clip (
    .clk           (clk),
    .load          (en2),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .s1            (s1),
    .s2            (s2)
  );

  // stage 3: address add (wraps at 22 bits), pack, zero when clipped
  assign addr_next = s2.row_base[ADDR_W-1:0] + {{(ADDR_W-COORD_W){1'b0}}, s2.col};

  always_ff @(posedge clk) begin
    if (en3) begin
      write_enable  <= s2.on;
      pixel_address <= s2.on ? addr_next : '0;
      blended_color <= s2.on ? {s2.r, s2.g, s2.b} : 16'h0000;
    end
  end

  assign res.valid         = v3;
  assign res.write_enable  = write_enable;
  assign res.pixel_address = pixel_address;
  assign res.blended_color = blended_color;

endmodule

// File: rtl/sab_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_check
// Port-level checks of the sprite blender, bound to the top level.
// ----------------------------------------------------------------------------
module sab_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        write_enable,
  input logic [21:0] pixel_address,
  input logic [15:0] blended_color
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(write_enable)
      && $stable(pixel_address) && $stable(blended_color))
    else $error("stalled result changed");

  // clipped pixels carry zero address and color
  a_clip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> pixel_address == 22'd0 && blended_color == 16'd0)
    else $error("clipped result not zeroed");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // an item taken with the receiver kept ready passes all stages and shows as a valid result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("item lost in pipeline");

endmodule

bind sprite_alpha_blend_rgb565 sab_check u_sab_check (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pix.valid),
  .in_ready      (pix.ready),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .write_enable  (res.write_enable),
  .pixel_address (res.pixel_address),
  .blended_color (res.blended_color)
);

// File: tb/sprite_alpha_blend_rgb565_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_alpha_blend_rgb565_checker
// Watches the pixel, result and register channels of the sprite blender,
// predicts each blended pixel and compares it with what the block returns.
// ----------------------------------------------------------------------------
module sprite_alpha_blend_rgb565_checker
  import sab_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sab_pix_if   pix,
  sab_res_if   res,
  sab_cfg_if   cfg,
  output int   errors,
  output int   outstanding,
  output int   results_seen,
  output int   writes_seen
);

  localparam int MAX_REPORTS = 30;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] pixel_address;
    logic [15:0]       blended_color;
  } blend_out_t;

  blend_out_t         pending_blends[$];
  logic [COORD_W-1:0] screen_w;
  logic [COORD_W-1:0] screen_h;
  int                 err_count;
  int                 result_count;
  int                 write_count;

  function automatic int weigh_channel(input int alpha, input int src, input int dst);
    return (alpha * src + (255 - alpha) * dst + 127) / 255;
  endfunction

  function automatic blend_out_t blend_pixel(
    input logic [7:0]         sb, sg, sr, alpha,
    input logic [15:0]        dc,
    input logic signed [11:0] ox, oy,
    input logic [5:0]         fx, fy
  );
    int         col;
    int         row;
    int         red;
    int         grn;
    int         blu;
    blend_out_t o;
    col = int'(ox) + int'(fx);
    row = int'(oy) + int'(fy);
    o = '0;
    if (fx < SPRITE_SIZE && fy < SPRITE_SIZE &&
        col >= 0 && col < int'(screen_w) && row >= 0 && row < int'(screen_h)) begin
      red = weigh_channel(int'(alpha), int'(sr[7:3]), int'(dc[15:11]));
      grn = weigh_channel(int'(alpha), int'(sg[7:2]), int'(dc[10:5]));
      blu = weigh_channel(int'(alpha), int'(sb[7:3]), int'(dc[4:0]));
      o.write_enable  = 1'b1;
      o.pixel_address = ADDR_W'(col + row * int'(screen_w));
      o.blended_color = {5'(red), 6'(grn), 5'(blu)};
    end
    return o;
  endfunction

  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  always @(posedge clk) begin
    blend_out_t want;
    if (rst) begin
      pending_blends.delete();
      screen_w = WIDTH_RESET;
      screen_h = HEIGHT_RESET;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SCREEN_WIDTH:  screen_w = cfg.data;
          REG_SCREEN_HEIGHT: screen_h = cfg.data;
          default: ;
        endcase
      end
      // a result never leaves in the same cycle as its pixel is taken, so pop first
      if (res.valid && res.ready) begin
        result_count++;
        if (res.write_enable === 1'b1)
          write_count++;
        if (pending_blends.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: result with no pixel waiting, actual we %0b addr %0h color %0h",
                     $time, res.write_enable, res.pixel_address, res.blended_color);
        end else begin
          want = pending_blends.pop_front();
          if (res.write_enable !== want.write_enable)
            flag_field("write_enable", want.write_enable, res.write_enable);
          if (res.pixel_address !== want.pixel_address)
            flag_field("pixel_address", want.pixel_address, res.pixel_address);
          if (res.blended_color !== want.blended_color)
            flag_field("blended_color", want.blended_color, res.blended_color);
        end
      end
      if (pix.valid && pix.ready)
        pending_blends.push_back(blend_pixel(pix.sprite_blue, pix.sprite_green,
                                             pix.sprite_red, pix.sprite_alpha,
                                             pix.dest_color, pix.origin_x, pix.origin_y,
                                             pix.offset_x, pix.offset_y));
    end
    errors       <= err_count;
    outstanding  <= pending_blends.size();
    results_seen <= result_count;
    writes_seen  <= write_count;
  end

endmodule

// File: tb/sprite_alpha_blend_rgb565_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_alpha_blend_rgb565_tb
// Drives sprite pixels through the blender under several screen sizes, with
// bursty input and a stalling output, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module sprite_alpha_blend_rgb565_tb;
  import sab_pkg::*;

  localparam int PIPE_DEPTH  = 3;       // register stages from pixel to result
  localparam int LONG_HOLD   = 300;     // cycles of the one long output stall
  localparam int CYCLE_LIMIT = 400000;  // far beyond the slowest clean run
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 225;

  typedef struct packed {
    logic [7:0]         sprite_blue;
    logic [7:0]         sprite_green;
    logic [7:0]         sprite_red;
    logic [7:0]         sprite_alpha;
    logic [15:0]        dest_color;
    logic signed [11:0] origin_x;
    logic signed [11:0] origin_y;
    logic [5:0]         offset_x;
    logic [5:0]         offset_y;
  } pixel_req_t;

  logic clk = 1'b0;
  logic rst;

  sab_pix_if pix_ch ();
  sab_res_if res_ch ();
  sab_cfg_if cfg_ch ();

  int errors;
  int outstanding;
  int results_seen;
  int writes_seen;
  int cycle_count = 0;
  int hold_req    = 0;  // bumped by the stimulus to ask for one long stall
  int items_sent  = 0;
  int sizes_used  = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sprite_alpha_blend_rgb565 dut (
    .clk (clk),
    .rst (rst),
    .pix (pix_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  sprite_alpha_blend_rgb565_checker blend_check (
    .clk          (clk),
    .rst          (rst),
    .pix          (pix_ch),
    .res          (res_ch),
    .cfg          (cfg_ch),
    .errors       (errors),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .writes_seen  (writes_seen)
  );

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("sprite_alpha_blend_rgb565_tb: done, errors");
      $finish;
    end
  end

  // output side: stretches of random length, each with its own stall style,
  // plus one long hold-off on request while the input keeps pushing
  initial begin
    int stretch;
    int style;
    int tick;
    int hold_done;
    hold_done = 0;
    res_ch.ready <= 1'b0;
    forever begin
      stretch = $urandom_range(8, 160);
      style   = $urandom_range(0, 3);
      for (tick = 0; tick < stretch; tick++) begin
        @(posedge clk);
        if (hold_req != hold_done) begin
          hold_done = hold_req;
          res_ch.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end else begin
          case (style)
            0:       res_ch.ready <= 1'b1;                      // no stalls
            1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       res_ch.ready <= ($urandom_range(0, 3) == 0); // mostly stalled
            default: res_ch.ready <= ((tick % 5) < 3);           // fixed rhythm
          endcase
        end
      end
    end
  end

  function automatic pixel_req_t mk_pixel(input int b, input int g, input int r,
                                          input int alpha, input int dest,
                                          input int ox, input int oy,
                                          input int fx, input int fy);
    pixel_req_t p;
    p.sprite_blue  = 8'(b);
    p.sprite_green = 8'(g);
    p.sprite_red   = 8'(r);
    p.sprite_alpha = 8'(alpha);
    p.dest_color   = 16'(dest);
    p.origin_x     = 12'(ox);
    p.origin_y     = 12'(oy);
    p.offset_x     = 6'(fx);
    p.offset_y     = 6'(fy);
    return p;
  endfunction

  // origin for one axis: mostly lands on screen, some near either screen edge,
  // some anywhere in the 12-bit range
  function automatic logic signed [11:0] pick_origin(input int span, input int ofs);
    int target;
    int pos;
    case ($urandom_range(0, 9))
      0, 1:    target = int'($urandom_range(0, 4095)) - 2048 + ofs;
      2, 3:    target = ($urandom_range(0, 1) ? span : 0) + int'($urandom_range(0, 6)) - 3;
      default: target = (span > 0) ? int'($urandom_range(0, span - 1))
                                   : int'($urandom_range(0, 40));
    endcase
    pos = target - ofs;
    if (pos > 2047)
      pos = 2047;
    if (pos < -2048)
      pos = -2048;
    return 12'(pos);
  endfunction

  function automatic pixel_req_t make_pixel(input int w, input int h);
    pixel_req_t p;
    p.sprite_blue  = 8'($urandom_range(0, 255));
    p.sprite_green = 8'($urandom_range(0, 255));
    p.sprite_red   = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       p.sprite_alpha = 8'h00;
      1:       p.sprite_alpha = 8'hFF;
      default: p.sprite_alpha = 8'($urandom_range(0, 255));
    endcase
    p.dest_color = 16'($urandom_range(0, 65535));
    p.offset_x   = 6'($urandom_range(0, 63));
    p.offset_y   = 6'($urandom_range(0, 63));
    p.origin_x   = pick_origin(w, int'(p.offset_x));
    p.origin_y   = pick_origin(h, int'(p.offset_y));
    return p;
  endfunction

  // present one pixel item and hold it until taken; valid stays high after
  task automatic offer_pixel(input pixel_req_t p);
    pix_ch.sprite_blue  <= p.sprite_blue;
    pix_ch.sprite_green <= p.sprite_green;
    pix_ch.sprite_red   <= p.sprite_red;
    pix_ch.sprite_alpha <= p.sprite_alpha;
    pix_ch.dest_color   <= p.dest_color;
    pix_ch.origin_x     <= p.origin_x;
    pix_ch.origin_y     <= p.origin_y;
    pix_ch.offset_x     <= p.offset_x;
    pix_ch.offset_y     <= p.offset_y;
    pix_ch.valid        <= 1'b1;
    do @(posedge clk); while (!pix_ch.ready);
    items_sent++;
  endtask

  // stop sending and wait until every predicted result has been returned
  task automatic drain_results();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  // both size registers back to back, valid held across the pair
  task automatic set_screen(input int w, input int h);
    cfg_ch.index <= REG_SCREEN_WIDTH;
    cfg_ch.data  <= 12'(w);
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_SCREEN_HEIGHT;
    cfg_ch.data  <= 12'(h);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sizes_used++;
  endtask

  initial begin
    int w;
    int h;
    int gap;
    int burst_left;
    rst                 <= 1'b1;
    pix_ch.valid        <= 1'b0;
    pix_ch.sprite_blue  <= '0;
    pix_ch.sprite_green <= '0;
    pix_ch.sprite_red   <= '0;
    pix_ch.sprite_alpha <= '0;
    pix_ch.dest_color   <= '0;
    pix_ch.origin_x     <= '0;
    pix_ch.origin_y     <= '0;
    pix_ch.offset_x     <= '0;
    pix_ch.offset_y     <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_SCREEN_WIDTH;
    cfg_ch.data         <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset size 1024 x 768
    offer_pixel(mk_pixel(0, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0));         // transparent keeps dest
    offer_pixel(mk_pixel(255, 255, 255, 255, 0, 0, 0, 0, 0));        // opaque white
    offer_pixel(mk_pixel(8'hAA, 8'h55, 8'hF0, 128, 16'h1234, 100, 200, 5, 7));
    offer_pixel(mk_pixel(255, 0, 255, 1, 16'hFFFF, 960, 704, 63, 63)); // last pixel on screen
    offer_pixel(mk_pixel(255, 0, 255, 1, 16'hFFFF, 961, 704, 63, 63)); // column = width
    offer_pixel(mk_pixel(255, 0, 255, 1, 16'hFFFF, 960, 705, 63, 63)); // row = height
    offer_pixel(mk_pixel(12, 34, 56, 200, 16'h8410, -1, 0, 0, 0));     // column -1
    offer_pixel(mk_pixel(12, 34, 56, 200, 16'h8410, 0, -1, 0, 0));     // row -1
    offer_pixel(mk_pixel(90, 80, 70, 60, 16'hF81F, -63, -63, 63, 63)); // back to origin
    offer_pixel(mk_pixel(1, 2, 3, 4, 16'h07E0, -2048, -2048, 0, 0));   // most negative
    offer_pixel(mk_pixel(1, 2, 3, 4, 16'h07E0, 2047, 2047, 63, 63));   // most positive
    offer_pixel(mk_pixel(7, 3, 7, 254, 0, 500, 300, 32, 16));         // dropped low bits
    drain_results();

    // one-pixel screen
    set_screen(1, 1);
    offer_pixel(mk_pixel(200, 100, 50, 77, 16'hABCD, 0, 0, 0, 0));
    offer_pixel(mk_pixel(200, 100, 50, 77, 16'hABCD, 0, 0, 1, 0));
    offer_pixel(mk_pixel(200, 100, 50, 77, 16'hABCD, 0, 0, 0, 1));
    drain_results();

    // zero width clips everything
    set_screen(0, 2048);
    offer_pixel(mk_pixel(255, 255, 255, 255, 16'hFFFF, 0, 0, 0, 0));
    offer_pixel(mk_pixel(255, 255, 255, 255, 16'hFFFF, 0, 2047, 0, 0));
    drain_results();

    // largest sizes, address wraps past 22 bits
    set_screen(4095, 4095);
    offer_pixel(mk_pixel(33, 66, 99, 150, 16'h5555, 2047, 2047, 63, 63));
    offer_pixel(mk_pixel(33, 66, 99, 150, 16'hAAAA, 2047, 0, 0, 0));
    offer_pixel(mk_pixel(33, 66, 99, 150, 16'hAAAA, -2048, 100, 0, 0));
    drain_results();

    // random phases, one screen size each
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       begin w = 1024; h = 768;  end
        1:       begin w = 2048; h = 2048; end
        2:       begin w = 640;  h = 480;  end
        3:       begin w = 1;    h = 1;    end
        4:       begin w = 0;    h = 2048; end
        5:       begin w = 4095; h = 4095; end
        6:       begin w = 2048; h = 0;    end
        default: begin
          w = $urandom_range(1, 2048);
          h = $urandom_range(1, 2048);
        end
      endcase
      set_screen(w, h);
      burst_left = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long output stall while the input keeps offering, so it backs up
        if (ph == 1 && i == 40)
          hold_req <= hold_req + 1;
        if (burst_left == 0) begin
          case ($urandom_range(0, 7))
            0, 1, 2, 3: gap = 0;
            4, 5, 6:    gap = $urandom_range(1, 5);
            default:    gap = $urandom_range(10, 30);
          endcase
          if (ph == 2)
            gap = 0;  // one phase with the input never idle
          if (gap != 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 40);
        end
        offer_pixel(make_pixel(w, h));
        burst_left--;
      end
      drain_results();
    end

    $display("covered %0d pixel items over %0d screen sizes incl. zero, 1x1, 2048 and 4095",
             items_sent, sizes_used);
    $display("checked %0d results: %0d on screen, %0d clipped; long output stall included",
             results_seen, writes_seen, results_seen - writes_seen);
    if (errors == 0) begin
      $display("sprite_alpha_blend_rgb565_tb: done, clean");
    end else begin
      $display("sprite_alpha_blend_rgb565_tb: done, errors");
    end
    $finish;
  end

endmodule
